>>> sv/cgf_pkg.sv
package cgf_pkg;

	// Field and register widths.
	localparam int PIX_W      = 8;
	localparam int SIZE_W     = 11;
	localparam int COEF_W     = 8;
	localparam int KROW_W     = 3 * COEF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = KROW_W;

	// Default maximum frame geometry.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Smallest frame size the counters honor.
	localparam int MIN_SIZE = 3;

	// Largest output value.
	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	// Register values after reset: 640x480 and the Sobel x-kernel.
	localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
	localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
	localparam logic [KROW_W-1:0] RST_KERNEL_TOP    = 24'd65791;
	localparam logic [KROW_W-1:0] RST_KERNEL_MIDDLE = 24'd131326;
	localparam logic [KROW_W-1:0] RST_KERNEL_BOTTOM = 24'd65791;

	// Job queue between the front and back halves.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One input beat.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pix_beat_t;

	// One result beat.
	typedef struct packed {
		logic [PIX_W-1:0] gradient;
		logic             frame_last;
	} res_beat_t;

	// Configuration registers; kernel[0] is the top row.
	typedef struct packed {
		logic [SIZE_W-1:0]           image_width;
		logic [SIZE_W-1:0]           image_height;
		logic [2:0][KROW_W-1:0]      kernel;
	} cfg_t;

	// One interior window: element row*3 + k, k = 0 oldest column.
	typedef struct packed {
		logic [8:0][PIX_W-1:0] pix;
		logic                  last;
	} job_t;

endpackage

>>> sv/conv3x3_gradient_filter_core.sv
// Streaming 3x3 convolution over 8-bit grey pixels in raster order, Sobel x by
// default. The block takes one pixel per clock while the job queue has room and
// returns one beat for every interior pixel (border rows and columns give none),
// the kernel sum saturated to 0..255, with frame_last set on the last interior
// pixel of the frame. The rate of one pixel per clock is set by the line buffer
// memory, which is read and written once per pixel, and a four-entry job queue
// lets the input and output sides stall independently. After reset the line
// buffer is swept to zero, and pix_ready stays low until the sweep ends;
// configuration writes are taken at any time and should be made while no pixel
// is in flight.
module conv3x3_gradient_filter_core import cgf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_beat_t             pix,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_beat_t             res
);

	cfg_t              cfg_q;
	logic              push;
	job_t              push_data;
	logic [QCNT_W-1:0] q_space;
	logic              job_valid, job_ready;
	job_t              job;

	// Configuration registers; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.kernel[0]    <= RST_KERNEL_TOP;
			cfg_q.kernel[1]    <= RST_KERNEL_MIDDLE;
			cfg_q.kernel[2]    <= RST_KERNEL_BOTTOM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[SIZE_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data[SIZE_W-1:0];
				end
				REG_KERNEL_TOP: begin
					cfg_q.kernel[0] <= cfg_data;
				end
				REG_KERNEL_MIDDLE: begin
					cfg_q.kernel[1] <= cfg_data;
				end
				REG_KERNEL_BOTTOM: begin
					cfg_q.kernel[2] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cgf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.q_space   (q_space),
		.push      (push),
		.push_data (push_data)
	);

	cgf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (q_space),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_data  (job)
	);

	cgf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

>>> sv/cgf_ram.sv
module cgf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/cgf_front.sv
module cgf_front import cgf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  pix_beat_t         pix,
	input  logic [QCNT_W-1:0] q_space,
	output logic              push,
	output job_t              push_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
	localparam int HW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] lower;
	} line_t;

	logic                  clear_q;
	logic [CW-1:0]         clr_addr_q;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic                  accept;
	logic [CW-1:0]         c;
	logic [RW-1:0]         r;
	logic [WW-1:0]         w_ext, w_lim, w_m1;
	logic [HW-1:0]         h_ext, h_lim, h_m1;
	logic                  last_col, last_row, interior;
	logic                  valid_s2, interior_s2, last_s2, fwd_s2;
	logic [PIX_W-1:0]      px_s2;
	logic [CW-1:0]         addr_s2;
	line_t                 fwd_data_s2;
	line_t                 rdata, line, wdata, ram_wdata;
	logic                  ram_we;
	logic [CW-1:0]         ram_waddr;
	logic [2:0][PIX_W-1:0] col3;
	logic [2:0][1:0][PIX_W-1:0] win_q;

	// Clamp the programmed frame size to the supported range.
	always_comb begin
		w_ext = WW'(cfg.image_width);
		if (w_ext < WW'(MIN_SIZE)) begin
			w_lim = WW'(MIN_SIZE);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_lim = WW'(MAX_WIDTH);
		end else begin
			w_lim = w_ext;
		end
		h_ext = HW'(cfg.image_height);
		if (h_ext < HW'(MIN_SIZE)) begin
			h_lim = HW'(MIN_SIZE);
		end else if (h_ext > HW'(MAX_HEIGHT)) begin
			h_lim = HW'(MAX_HEIGHT);
		end else begin
			h_lim = h_ext;
		end
		w_m1 = w_lim - WW'(1);
		h_m1 = h_lim - HW'(1);
	end

	// Position of the incoming pixel and its class.
	assign c        = pix.frame_start ? '0 : col_q;
	assign r        = pix.frame_start ? '0 : row_q;
	assign last_col = WW'(c) >= w_m1;
	assign last_row = HW'(r) >= h_m1;
	assign interior = (r >= RW'(2)) && (c >= CW'(2));

	// Take a beat only when the queue has room for it and for the one in flight.
	assign pix_ready = !clear_q && (q_space > {{(QCNT_W-1){1'b0}}, valid_s2});
	assign accept    = pix_valid && pix_ready;

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : RW'(r + RW'(1));
			end else begin
				col_q <= CW'(c + CW'(1));
				row_q <= r;
			end
		end
	end

	// After reset the line buffers are swept to zero, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= CW'(clr_addr_q + CW'(1));
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Second stage: valid and the forward flag, which marks a read of the entry
	// being written in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			fwd_s2   <= 1'b0;
		end else begin
			valid_s2 <= accept;
			fwd_s2   <= accept && valid_s2 && (c == addr_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s2       <= pix.pixel;
			addr_s2     <= c;
			interior_s2 <= interior;
			last_s2     <= last_col && last_row;
			fwd_data_s2 <= wdata;
		end
	end

	// Both line buffers share one entry per column: upper holds row r-2, lower row r-1.
	assign line    = fwd_s2 ? fwd_data_s2 : rdata;
	assign col3[0] = line.upper;
	assign col3[1] = line.lower;
	assign col3[2] = px_s2;
	assign wdata   = '{upper: line.lower, lower: px_s2};

	always_comb begin
		if (clear_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s2;
			ram_waddr = addr_s2;
			ram_wdata = wdata;
		end
	end

	cgf_ram #(
		.WIDTH ($bits(line_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (c),
		.rdata (rdata)
	);

	// The window keeps the two older columns of the three rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s2) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= col3[i];
			end
		end
	end

	// Interior pixels hand their full window to the back half.
	assign push = valid_s2 && interior_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			push_data.pix[i*3]     = win_q[i][0];
			push_data.pix[i*3 + 1] = win_q[i][1];
			push_data.pix[i*3 + 2] = col3[i];
		end
		push_data.last = last_s2;
	end

	// The sweep ends exactly on the last entry.
	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clear_q) |-> $past(clr_addr_q) == CW'(MAX_WIDTH - 1))
		else $error("line buffer sweep ended early");

	// Forwarding only ever applies to a live second-stage beat.
	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s2 |-> valid_s2)
		else $error("forward flag without a beat in stage two");

endmodule

>>> sv/cgf_queue.sv
module cgf_queue import cgf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  job_t              push_data,
	output logic [QCNT_W-1:0] space,
	output logic              pop_valid,
	input  logic              pop_ready,
	output job_t              pop_data
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign space     = QCNT_W'(QUEUE_DEPTH) - count_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					QPTR_W'(wr_ptr_q + QPTR_W'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					QPTR_W'(rd_ptr_q + QPTR_W'(1));
			end
			if (push && !pop) begin
				count_q <= QCNT_W'(count_q + QCNT_W'(1));
			end else if (pop && !push) begin
				count_q <= QCNT_W'(count_q - QCNT_W'(1));
			end
		end
	end

	// The front must never write into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != QCNT_W'(QUEUE_DEPTH) || pop)
		else $error("job queue overflow");

	// A lone push grows the queue by exactly one entry.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == QCNT_W'($past(count_q) + QCNT_W'(1)))
		else $error("job queue count out of step");

endmodule

>>> sv/cgf_back.sv
module cgf_back import cgf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      res_valid,
	input  logic      res_ready,
	output res_beat_t res
);

	localparam int PROD_W = PIX_W + 1 + COEF_W;
	localparam int RSUM_W = PROD_W + 2;
	localparam int SUM_W  = RSUM_W + 2;
	localparam logic signed [SUM_W-1:0] SAT_HI = $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX});

	logic signed [PROD_W-1:0] prod_s1 [9];
	logic signed [RSUM_W-1:0] rsum_s2 [3];
	logic signed [SUM_W-1:0]  total;
	logic                     valid_s1, valid_s2, valid_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [PIX_W-1:0]         gradient_s3;
	logic                     adv1, adv2, adv3;

	// Each stage moves when the one after it is empty or moving.
	assign adv3      = !valid_s3 || res_ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign job_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= job_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage one: nine pixel by coefficient products.
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int rr = 0; rr < 3; rr++) begin
				for (int kk = 0; kk < 3; kk++) begin
					prod_s1[rr*3 + kk] <= $signed({1'b0, job.pix[rr*3 + kk]}) *
						$signed(cfg.kernel[rr][kk*COEF_W +: COEF_W]);
				end
			end
			last_s1 <= job.last;
		end
	end

	// Stage two: one sum per kernel row.
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int rr = 0; rr < 3; rr++) begin
				rsum_s2[rr] <= RSUM_W'(prod_s1[rr*3]) + RSUM_W'(prod_s1[rr*3 + 1]) +
					RSUM_W'(prod_s1[rr*3 + 2]);
			end
			last_s2 <= last_s1;
		end
	end

	// Stage three: total and saturation into the output register.
	assign total = SUM_W'(rsum_s2[0]) + SUM_W'(rsum_s2[1]) + SUM_W'(rsum_s2[2]);

	always_ff @(posedge clk) begin
		if (adv3) begin
			if (total < 0) begin
				gradient_s3 <= '0;
			end else if (total > SAT_HI) begin
				gradient_s3 <= PIX_MAX;
			end else begin
				gradient_s3 <= total[PIX_W-1:0];
			end
			last_s3 <= last_s2;
		end
	end

	assign res_valid      = valid_s3;
	assign res.gradient   = gradient_s3;
	assign res.frame_last = last_s3;

endmodule

>>> verif/conv3x3_gradient_filter_core_test.sv
`timescale 1ns / 1ps

module conv3x3_gradient_filter_core_test;

	import cgf_pkg::*;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// Receiver hold-off length, in cycles.
	localparam int HOLD_CYCLES = 300;

	// Tracks the filter state and queues the gradient each pixel beat should produce.
	class gradient_scoreboard;
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		logic [2:0][KROW_W-1:0] kernel_rows;
		logic [PIX_W-1:0] upper_line[DEF_MAX_WIDTH];
		logic [PIX_W-1:0] lower_line[DEF_MAX_WIDTH];
		logic [PIX_W-1:0] window[6];
		int unsigned col_pos;
		int unsigned row_pos;
		res_beat_t expected_results[$];
		int failures;

		function new();
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			kernel_rows[0] = RST_KERNEL_TOP;
			kernel_rows[1] = RST_KERNEL_MIDDLE;
			kernel_rows[2] = RST_KERNEL_BOTTOM;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			col_pos = 0;
			row_pos = 0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:   width_reg = data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:  height_reg = data[SIZE_W-1:0];
				REG_KERNEL_TOP:    kernel_rows[0] = data[KROW_W-1:0];
				REG_KERNEL_MIDDLE: kernel_rows[1] = data[KROW_W-1:0];
				REG_KERNEL_BOTTOM: kernel_rows[2] = data[KROW_W-1:0];
				default: ;
			endcase
		endfunction

		// Sizes below the minimum act as the minimum, above the maximum as the maximum.
		function int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned limit);
			if (v < MIN_SIZE)
				return MIN_SIZE;
			if (v > limit)
				return limit;
			return v;
		endfunction

		function int unsigned frame_length();
			return clamp_dim(width_reg, DEF_MAX_WIDTH) * clamp_dim(height_reg, DEF_MAX_HEIGHT);
		endfunction

		function int coef(int krow, int pos);
			return int'($signed(kernel_rows[krow][COEF_W*pos +: COEF_W]));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// One accepted pixel beat: advance the window and predict its result, if any.
		function void note_pixel(pix_beat_t beat);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int unsigned r;
			int sum;
			logic [PIX_W-1:0] column[3];
			logic last_col;
			logic last_row;
			res_beat_t want;
			w = clamp_dim(width_reg, DEF_MAX_WIDTH);
			h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
			if (beat.frame_start) begin
				col_pos = 0;
				row_pos = 0;
			end
			c = col_pos;
			r = row_pos;
			if (c >= DEF_MAX_WIDTH)
				c = DEF_MAX_WIDTH - 1;
			column[0] = upper_line[c];
			column[1] = lower_line[c];
			column[2] = beat.pixel;
			last_col = (c >= w - 1);
			last_row = (r >= h - 1);

			// Interior pixels only: exact sum, then saturate to the pixel range.
			if (r >= 2 && c >= 2) begin
				sum = 0;
				for (int i = 0; i < 3; i++)
					sum += int'(window[2*i]) * coef(i, 0) + int'(window[2*i+1]) * coef(i, 1)
						+ int'(column[i]) * coef(i, 2);
				if (sum < 0)
					sum = 0;
				if (sum > 255)
					sum = 255;
				want.gradient = PIX_W'(sum);
				want.frame_last = last_col && last_row;
				expected_results.push_back(want);
			end

			for (int i = 0; i < 3; i++) begin
				window[2*i] = window[2*i+1];
				window[2*i+1] = column[i];
			end
			upper_line[c] = column[1];
			lower_line[c] = beat.pixel;

			// Counters wrap at the row end and at the frame end by themselves.
			if (last_col) begin
				col_pos = 0;
				row_pos = last_row ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end
		endfunction

		// One accepted result beat against the oldest prediction.
		function void check_result(res_beat_t got);
			res_beat_t want;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result: gradient %0d frame_last %0b",
						$time, got.gradient, got.frame_last);
				return;
			end
			want = expected_results.pop_front();
			if (got.gradient !== want.gradient || got.frame_last !== want.frame_last) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch: expected gradient %0d frame_last %0b, got %0d %0b",
						$time, want.gradient, want.frame_last, got.gradient, got.frame_last);
			end
		endfunction

		// Anything still queued at the end never arrived.
		function void close();
			if (expected_results.size() != 0) begin
				failures += expected_results.size();
				$display("%0t: %0d expected results never arrived", $time,
					expected_results.size());
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pix_valid;
	logic                  pix_ready;
	pix_beat_t             pix;
	logic                  res_valid;
	logic                  res_ready;
	res_beat_t             res;

	gradient_scoreboard filter_model;
	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_request;

	conv3x3_gradient_filter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: check every accepted beat, stall at random, and hold off once.
	initial begin : result_sink
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready)
				filter_model.check_result(res);
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= !(rx_idle_on && $urandom_range(99) < 12);
			end
		end
	end

	// Write one register and record it once the beat is taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		filter_model.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
			input logic [KROW_W-1:0] bot);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_KERNEL_TOP, top);
		write_reg(REG_KERNEL_MIDDLE, mid);
		write_reg(REG_KERNEL_BOTTOM, bot);
	endtask

	// Offer one pixel beat, after an optional random gap, and wait until it is taken.
	task automatic send_pixel(input logic [PIX_W-1:0] value, input logic start);
		if (tx_idle_on) begin
			while ($urandom_range(99) < 12) begin
				pix_valid <= 1'b0;
				@(posedge clk);
			end
		end
		pix_valid <= 1'b1;
		pix <= '{pixel: value, frame_start: start};
		do @(posedge clk); while (!pix_ready);
		filter_model.note_pixel('{pixel: value, frame_start: start});
	endtask

	// Stop sending, let every expected result drain, then cover the pipeline latency.
	task automatic wait_idle();
		int guard;
		guard = 0;
		pix_valid <= 1'b0;
		while (filter_model.pending() > 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (16) @(posedge clk);
	endtask

	function automatic logic [KROW_W-1:0] small_kernel_row();
		logic [KROW_W-1:0] row;
		for (int k = 0; k < 3; k++)
			row[COEF_W*k +: COEF_W] = COEF_W'(int'($urandom_range(6)) - 3);
		return row;
	endfunction

	// Random geometry, mostly small frames, with junk above the size bits.
	task automatic random_setup();
		logic [CFG_DATA_W-1:0] w_word;
		logic [CFG_DATA_W-1:0] h_word;
		logic [KROW_W-1:0] rows[3];
		int kmode;
		w_word = CFG_DATA_W'($urandom());
		h_word = CFG_DATA_W'($urandom());
		w_word[SIZE_W-1:0] = ($urandom_range(99) < 85) ? SIZE_W'($urandom_range(3, 12))
			: SIZE_W'($urandom_range(2));
		h_word[SIZE_W-1:0] = ($urandom_range(99) < 85) ? SIZE_W'($urandom_range(3, 6))
			: SIZE_W'($urandom_range(2));
		kmode = $urandom_range(4);
		if (kmode < 2) begin
			foreach (rows[k]) rows[k] = small_kernel_row();
		end else if (kmode < 4) begin
			foreach (rows[k]) rows[k] = KROW_W'($urandom());
		end else begin
			rows[0] = RST_KERNEL_TOP;
			rows[1] = RST_KERNEL_MIDDLE;
			rows[2] = RST_KERNEL_BOTTOM;
		end
		configure(w_word, h_word, rows[0], rows[1], rows[2]);
	endtask

	// Mostly whole frames with random content; now and then a start is dropped or
	// a new frame starts in the middle of one.
	task automatic random_frames(input int n_items, input bit resume);
		int frame_pos;
		int frame_len;
		int pix_mode;
		int base;
		logic [PIX_W-1:0] value;
		logic start;
		frame_len = filter_model.frame_length();
		pix_mode = $urandom_range(2);
		base = $urandom_range(252);
		frame_pos = resume ? 1 : 0;
		for (int n = 0; n < n_items; n++) begin
			case (pix_mode)
				0: value = PIX_W'($urandom_range(255));
				1: value = PIX_W'(base + $urandom_range(3));
				default: value = $urandom_range(1) ? PIX_MAX : '0;
			endcase
			start = (frame_pos == 0);
			if (start && $urandom_range(99) < 5)
				start = 1'b0;
			else if (!start && $urandom_range(99) < 1)
				start = 1'b1;
			if (start)
				frame_pos = 0;
			send_pixel(value, start);
			frame_pos = (frame_pos + 1) % frame_len;
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix_valid <= 1'b0;
		pix <= '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_request = 1'b0;
		filter_model = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest frames under the Sobel kernel: a saturating edge, then a mild ramp.
		configure(24'd3, 24'd3, RST_KERNEL_TOP, RST_KERNEL_MIDDLE, RST_KERNEL_BOTTOM);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
		for (int k = 0; k < 9; k++)
			send_pixel((k % 3 == 2) ? PIX_MAX : 8'd0, k == 0);
		for (int k = 0; k < 9; k++)
			send_pixel(PIX_W'(10 * (k % 3 + 1)), k == 0);
		wait_idle();

		// Sizes below the minimum, extreme coefficients, a sum just below zero.
		configure(24'd0, 24'd2, 24'h7F7F7F, 24'h000000, 24'h808080);
		for (int k = 0; k < 9; k++)
			send_pixel((k < 6) ? PIX_MAX : 8'd254, k == 0);
		wait_idle();

		// Random phases; the first two run without any idling, one holds off the receiver,
		// and some continue the previous frame under a new size.
		for (int phase = 0; phase < 8; phase++) begin
			random_setup();
			tx_idle_on = (phase >= 2);
			rx_idle_on = (phase >= 2);
			if (phase == 3)
				hold_request = 1'b1;
			random_frames(175, phase % 3 == 2);
			wait_idle();
		end

		filter_model.close();
		if (filter_model.failures == 0)
			$display("** conv3x3_gradient_filter_core: PASSED **");
		else
			$display("** conv3x3_gradient_filter_core: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("** conv3x3_gradient_filter_core: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
sv/cgf_pkg.sv
sv/cgf_ram.sv
sv/cgf_front.sv
sv/cgf_queue.sv
sv/cgf_back.sv
sv/conv3x3_gradient_filter_core.sv
verif/conv3x3_gradient_filter_core_test.sv
